>>> design/bba_pkg.sv
// shared types and constants for the block bitmap allocator
package bba_pkg;

  // block number field width and the largest count it can address
  localparam int BLK_W             = 10;
  localparam int BLOCK_FIELD_LIMIT = 1 << BLK_W;
  localparam int STAT_W            = 2;

  // default geometry
  localparam int DEF_TOTAL_BLOCKS = 1024;
  localparam int DEF_WORD_BITS    = 32;

  // request codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_REM,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN_RD,
    S_SCAN,
    S_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load_req;
    logic    calc_quot;
    logic    calc_rem;
    logic    mem_rd;
    logic    scan_step;
    logic    free_wr;
    logic    alloc_wr;
    logic    res_load;
    status_t res_code;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;
    logic range_err;
    logic first_oob;
    logic found;
    logic last_word;
  } dp_stat_t;

endpackage

>>> design/bba_if.sv
// request, result and configuration channel interfaces

interface bba_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [bba_pkg::BLK_W-1:0] block_id;

  modport source (output valid, output command, output block_id, input ready);
  modport sink   (input valid, input command, input block_id, output ready);
endinterface

interface bba_out_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::BLK_W-1:0]  allocated_block;
  logic [bba_pkg::STAT_W-1:0] status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

interface bba_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [bba_pkg::BLK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/block_bitmap_allocator_unit.sv
// top level of the first-fit block bitmap allocator
// One request at a time. A free splits the block number into word and bit, reads that
// word and writes it back with the bit cleared; an allocate splits the first data block
// the same way and examines bitmap words starting at the word that holds it, at most
// ceil(min(TOTAL_BLOCKS,1024)/WORD_BITS) words. A free of a block number past the disk,
// or an allocate whose first data block lies at or past the allocation limit, answers
// from the split without touching the bitmap. The search walks the single read port
// of the bitmap memory one word per cycle; the split finds quotient, then remainder.
// Results wait in an output register, so a new request is taken while the previous
// result is still pending. After reset every block reads as free at once through
// per-word valid bits; there is no clearing pass. The configuration channel is always
// ready, to be written only while the block is idle; the block does not enforce this.
module block_bitmap_allocator_unit #(
  parameter int TOTAL_BLOCKS = bba_pkg::DEF_TOTAL_BLOCKS,
  parameter int WORD_BITS    = bba_pkg::DEF_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);
  import bba_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // configuration channel never stalls
  assign cfg_ch.ready = 1'b1;

  // controller
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  bba_dpath #(
    .TOTAL_BLOCKS (TOTAL_BLOCKS),
    .WORD_BITS    (WORD_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_command          (in_ch.command),
    .in_block_id         (in_ch.block_id),
    .cfg_we              (cfg_ch.valid),
    .cfg_data            (cfg_ch.data),
    .out_allocated_block (out_ch.allocated_block),
    .out_status          (out_ch.status)
  );

endmodule

>>> design/bba_ctrl.sv
// controller state machine for the block bitmap allocator
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::ctrl_cmd_t cmd
);
  import bba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_QUOT;
      end
      S_QUOT: state_nxt = S_REM;
      S_REM: begin
        if (stat.is_free) begin
          state_nxt = stat.range_err ? S_RESP : S_FREE_RD;
        end else begin
          state_nxt = stat.first_oob ? S_RESP : S_SCAN_RD;
        end
      end
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_RESP;
      S_SCAN_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.found || stat.last_word) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_FULL;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_QUOT: cmd.calc_quot = 1'b1;
      S_REM: begin
        cmd.calc_rem = 1'b1;
        if (stat.is_free && stat.range_err) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_RANGE;
        end else if (!stat.is_free && stat.first_oob) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
        end
      end
      S_FREE_RD: cmd.mem_rd = 1'b1;
      S_FREE_WR: begin
        cmd.free_wr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_FREED;
      end
      S_SCAN_RD: cmd.mem_rd = 1'b1;
      S_SCAN: begin
        if (stat.found) begin
          cmd.alloc_wr = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_ALLOCATED;
        end else if (stat.last_word) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESP: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.out_load)      out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/bba_dpath.sv
// datapath: bitmap memory, word/bit split, first-fit search and result registers
module bba_dpath #(
  parameter int TOTAL_BLOCKS = bba_pkg::DEF_TOTAL_BLOCKS,
  parameter int WORD_BITS    = bba_pkg::DEF_WORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bba_pkg::ctrl_cmd_t         cmd,
  output bba_pkg::dp_stat_t          stat,
  input  logic                       in_command,
  input  logic [bba_pkg::BLK_W-1:0]  in_block_id,
  input  logic                       cfg_we,
  input  logic [bba_pkg::BLK_W-1:0]  cfg_data,
  output logic [bba_pkg::BLK_W-1:0]  out_allocated_block,
  output logic [bba_pkg::STAT_W-1:0] out_status
);
  import bba_pkg::*;

  // geometry
  localparam int BLK_LIMIT = (TOTAL_BLOCKS < BLOCK_FIELD_LIMIT) ? TOTAL_BLOCKS
                                                                : BLOCK_FIELD_LIMIT;
  localparam int DEPTH     = (BLK_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LAST      = DEPTH - 1;
  localparam int TAIL      = BLK_LIMIT - LAST * WORD_BITS;

  // reciprocal for the block to word split
  localparam int DIV_K  = 20;
  localparam int DIV_M  = (1 << DIV_K) / WORD_BITS;
  localparam int M_W    = DIV_K - 2;
  localparam int PROD_W = BLK_W + M_W;
  localparam int Q_W    = PROD_W - DIV_K;

  logic                 cmd_r;
  logic [BLK_W-1:0]     id_r;
  logic [BLK_W-1:0]     first_r;
  logic [Q_W-1:0]       q_r;
  logic [ADDR_W-1:0]    word_r;
  logic [BLK_W-1:0]     base_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 head_r;
  logic [BLK_W-1:0]     res_block_r;
  status_t              res_status_r;
  logic [BLK_W-1:0]     out_block_r;
  status_t              out_status_r;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [BLK_W-1:0]     x;
  logic [PROD_W-1:0]    prod;
  logic [BLK_W-1:0]     qb;
  logic [BLK_W-1:0]     rem;
  logic                 corr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] word_val;
  logic [WORD_BITS-1:0] busy;
  logic [WORD_BITS-1:0] wr_data;
  logic                 found;
  logic [BIT_W-1:0]     idx;
  logic                 last_word;

  // request capture and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
    end else if (cfg_we) begin
      first_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_r <= in_command;
      id_r  <= in_block_id;
    end
  end

  // operand for the split: block to free or first data block
  assign x = (cmd_r == CMD_FREE) ? id_r : first_r;

  // quotient estimate by reciprocal multiply
  assign prod = PROD_W'(x) * PROD_W'(DIV_M);

  always_ff @(posedge clk) begin
    if (cmd.calc_quot) q_r <= prod[PROD_W-1 -: Q_W];
  end

  // remainder with one correction step
  assign qb   = BLK_W'(BLK_W'(q_r) * BLK_W'(WORD_BITS));
  assign rem  = x - qb;
  assign corr = rem >= BLK_W'(WORD_BITS);

  assign last_word = (word_r == ADDR_W'(LAST));

  // word pointer, word base block and bit offset
  always_ff @(posedge clk) begin
    if (cmd.calc_rem) begin
      word_r <= ADDR_W'(BLK_W'(q_r) + BLK_W'(corr));
      base_r <= corr ? BLK_W'(qb + BLK_W'(WORD_BITS)) : qb;
      bit_r  <= corr ? BIT_W'(rem - BLK_W'(WORD_BITS)) : BIT_W'(rem);
      head_r <= 1'b1;
    end else if (cmd.scan_step) begin
      word_r <= word_r + ADDR_W'(1);
      base_r <= BLK_W'(base_r + BLK_W'(WORD_BITS));
      head_r <= 1'b0;
    end
  end

  // bitmap memory, one read port and one write port
  assign rd_addr = cmd.scan_step ? (word_r + ADDR_W'(1)) : word_r;
  assign rd_en   = cmd.mem_rd || cmd.scan_step;
  assign wr_en   = cmd.free_wr || cmd.alloc_wr;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (wr_en) mem[word_r] <= wr_data;
  end

  // word valid bits; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[word_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_vld_r <= vld_r[rd_addr];
  end

  assign word_val = rd_vld_r ? rd_data_r : '0;

  // mask bits below the first data block and past the last block
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      busy[b] = word_val[b]
              || (head_r && (BIT_W'(b) < bit_r))
              || (last_word && (b >= TAIL));
    end
  end

  // lowest free bit
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!busy[b]) begin
        found = 1'b1;
        idx   = BIT_W'(b);
      end
    end
  end

  // write-back word: set on allocate, clear on free
  always_comb begin
    wr_data = word_val;
    if (cmd.free_wr) wr_data[bit_r] = 1'b0;
    else             wr_data[idx]   = 1'b1;
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_code;
      res_block_r  <= (cmd.res_code == ST_ALLOCATED) ? BLK_W'(base_r + BLK_W'(idx)) : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_block_r  <= res_block_r;
    end
  end

  assign out_allocated_block = out_block_r;
  assign out_status          = out_status_r;

  // status to the controller
  assign stat.is_free   = (cmd_r == CMD_FREE);
  assign stat.range_err = (32'(id_r) >= TOTAL_BLOCKS);
  assign stat.first_oob = (32'(first_r) >= BLK_LIMIT);
  assign stat.found     = found;
  assign stat.last_word = last_word;

endmodule

>>> tb/sv/bba_alloc_checker.sv
`timescale 1ns / 100ps
// allocator result checker: tracks the block bitmap and compares every result
module bba_alloc_checker #(
  parameter int TOTAL_BLOCKS = bba_pkg::DEF_TOTAL_BLOCKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_command,
  input  logic [bba_pkg::BLK_W-1:0]   in_block_id,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [bba_pkg::BLK_W-1:0]   out_allocated_block,
  input  logic [bba_pkg::STAT_W-1:0]  out_status,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bba_pkg::BLK_W-1:0]   cfg_data,
  output int                          mismatch_count,
  output int                          outstanding
);
  import bba_pkg::*;

  // allocation never hands out a number that does not fit the result field
  localparam int ALLOC_CEIL = (TOTAL_BLOCKS < BLOCK_FIELD_LIMIT) ? TOTAL_BLOCKS
                                                                 : BLOCK_FIELD_LIMIT;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_t          status;
  } outcome_t;

  // one bit per block, set means in use
  bit               block_used [TOTAL_BLOCKS];
  logic [BLK_W-1:0] first_data_block;
  outcome_t         pending_outcomes [$];
  outcome_t         oldest;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  // first-fit search on allocate, bit clear on free
  function automatic outcome_t apply_request(input cmd_t cmd, input logic [BLK_W-1:0] id);
    outcome_t res;
    int       b;
    res.blk    = '0;
    res.status = ST_FULL;
    if (cmd == CMD_ALLOC) begin
      for (b = int'(first_data_block); b < ALLOC_CEIL && res.status == ST_FULL; b++) begin
        if (!block_used[b]) begin
          block_used[b] = 1'b1;
          res.blk       = BLK_W'(b);
          res.status    = ST_ALLOCATED;
        end
      end
    end else if (int'(id) >= TOTAL_BLOCKS) begin
      res.status = ST_RANGE;
    end else begin
      block_used[id] = 1'b0;
      res.status     = ST_FREED;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (block_used[b]) block_used[b] = 1'b0;
      first_data_block = '0;
      pending_outcomes.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: block %0d status %0d",
                                    out_allocated_block, out_status));
        end else begin
          oldest = pending_outcomes.pop_front();
          if (out_allocated_block !== oldest.blk)
            report_mismatch($sformatf("allocated_block %0d, predicted %0d",
                                      out_allocated_block, oldest.blk));
          if (out_status !== oldest.status)
            report_mismatch($sformatf("status %0d, predicted %s",
                                      out_status, oldest.status.name()));
        end
      end
      // register write
      if (cfg_valid && cfg_ready) first_data_block = cfg_data;
      // accepted request updates the bitmap copy
      if (in_valid && in_ready)
        pending_outcomes.push_back(apply_request(cmd_t'(in_command), in_block_id));
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

>>> tb/sv/tb_block_bitmap_allocator_unit.sv
`timescale 1ns / 100ps
// testbench top: directed and random allocate/free traffic with a result checker
module tb_block_bitmap_allocator_unit;
  import bba_pkg::*;

  localparam int TOTAL_BLOCKS   = DEF_TOTAL_BLOCKS;
  localparam int WORD_BITS      = DEF_WORD_BITS;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 105;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  int   idle_cycles;
  bit   steady;
  bit   hold_results;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();
  bba_cfg_if cfg_ch ();

  block_bitmap_allocator_unit #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS),
    .WORD_BITS   (WORD_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  bba_alloc_checker #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS)
  ) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_command         (in_ch.command),
    .in_block_id        (in_ch.block_id),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_allocated_block(out_ch.allocated_block),
    .out_status         (out_ch.status),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_data           (cfg_ch.data),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one request after a random gap and hold it until taken
  task automatic send_request(input cmd_t cmd, input logic [BLK_W-1:0] id);
    int gap;
    gap = steady ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.block_id <= id;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_first_block(input logic [BLK_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = steady ? 0 : $urandom_range(3, 0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[block_bitmap_allocator_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int               phase;
    int               alloc_pct;
    int               upper;
    logic [BLK_W-1:0] fdb;
    logic [BLK_W-1:0] free_id;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_ALLOC;
    in_ch.block_id <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    steady         = 1'b0;
    hold_results   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // allocation from block zero, double free, frees of the top block and alternating-bit numbers
    write_first_block('0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '1);
    send_request(CMD_FREE, '0);
    send_request(CMD_FREE, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, '1);
    send_request(CMD_FREE, 10'h2AA);
    send_request(CMD_FREE, 10'h155);

    // first data block at the top: one allocation then full, free below it
    write_first_block('1);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 10'd5);
    send_request(CMD_FREE, '1);
    send_request(CMD_ALLOC, '0);

    // fill the tail of the disk until it reports full
    write_first_block(10'd1016);
    repeat (8) send_request(CMD_ALLOC, '0);

    // random phases, each with its own first data block and command mix
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        fdb = '0;
      else if (phase == 1)
        fdb = '1;
      else if ($urandom_range(1, 0) == 1)
        fdb = BLK_W'($urandom_range(1023, 0));
      else
        fdb = BLK_W'($urandom_range(1023, 900));
      write_first_block(fdb);
      steady = (phase % 3 == 2);
      if (phase == 4) begin
        steady       = 1'b1;
        hold_results = 1'b1;
      end
      alloc_pct = $urandom_range(90, 40);
      repeat (PHASE_REQUESTS) begin
        if ($urandom_range(99, 0) < alloc_pct) begin
          send_request(CMD_ALLOC, BLK_W'($urandom));
        end else begin
          // half the frees aim at blocks just handed out
          upper = (int'(fdb) > 960) ? 1023 : int'(fdb) + 63;
          if ($urandom_range(1, 0) == 1)
            free_id = BLK_W'($urandom);
          else
            free_id = BLK_W'($urandom_range(upper, int'(fdb)));
          send_request(CMD_FREE, free_id);
        end
      end
    end

    // drain, then watch a while for stray results
    steady = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[block_bitmap_allocator_unit] OK");
    else
      $display("[block_bitmap_allocator_unit] ERROR");
    $finish;
  end

endmodule

>>> block_bitmap_allocator_unit.f
design/bba_pkg.sv
design/bba_if.sv
design/bba_ctrl.sv
design/bba_dpath.sv
design/block_bitmap_allocator_unit.sv
tb/sv/bba_alloc_checker.sv
tb/sv/tb_block_bitmap_allocator_unit.sv
